// ----- src/necir_pkg.sv -----
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types and constants for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package necir_pkg;

  localparam int unsigned TIME_BITS_DEF = 15;
  localparam int unsigned GLITCH_LIMIT  = 100;
  localparam int unsigned NOISE_LIMIT   = 8000;
  localparam int unsigned CODE_BITS     = 32;
  localparam int unsigned BIT_COUNT_W   = 6;
  localparam int unsigned CFG_INDEX_W   = 3;

  localparam int unsigned MARGIN_RST     = 400;
  localparam int unsigned LEAD_HIGH_RST  = 9000;
  localparam int unsigned LEAD_LOW_RST   = 4500;
  localparam int unsigned REPEAT_LOW_RST = 2250;
  localparam int unsigned MARK_RST       = 560;
  localparam int unsigned ONE_SPACE_RST  = 1690;
  localparam int unsigned ZERO_SPACE_RST = 560;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MARGIN     = 3'd0,
    REG_LEAD_HIGH  = 3'd1,
    REG_LEAD_LOW   = 3'd2,
    REG_REPEAT_LOW = 3'd3,
    REG_MARK       = 3'd4,
    REG_ONE_SPACE  = 3'd5,
    REG_ZERO_SPACE = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CODE   = 2'd0,
    ST_REPEAT = 2'd1,
    ST_FAIL   = 2'd2,
    ST_NOISE  = 2'd3
  } status_t;

endpackage : necir_pkg

`default_nettype wire

// ----- src/necir_window.sv -----
// ----------------------------------------------------------------------------
// necir_window
// Tolerance window check: target - margin (floored at zero) <= value <=
// target + margin, both bounds inclusive.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_window #(
  parameter int unsigned TIME_BITS = 15
) (
  input  wire logic [TIME_BITS-1:0] value,
  input  wire logic [TIME_BITS-1:0] target,
  input  wire logic [TIME_BITS-1:0] margin,
  output logic                      hit
);

  logic [TIME_BITS-1:0] lo_bound;
  logic [TIME_BITS:0]   hi_bound;

  always_comb begin
    lo_bound = (target > margin) ? (target - margin) : '0;
    hi_bound = {1'b0, target} + {1'b0, margin};
    hit      = (value >= lo_bound) && ({1'b0, value} <= hi_bound);
  end

endmodule : necir_window

`default_nettype wire

// ----- src/nec_ir_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// NEC infrared frame decoder: checks pulse symbols against configured
// windows, collects 32 data bits LSB first and reports one status per frame.
// ----------------------------------------------------------------------------
// Path from input request to result: input register, then result register.
// Throughput: one symbol per cycle; a frame-final symbol waits only while the
// result register is full and not being taken.
// Reset (rst, synchronous): frame state cleared, both stages empty, config
// registers back to their defaults.
`default_nettype none

module nec_ir_frame_decoder_core
  import necir_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [TIME_BITS-1:0]   cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [TIME_BITS-1:0]   high_time,
  input  wire logic [TIME_BITS-1:0]   low_time,
  input  wire logic                   last_symbol,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic [CODE_BITS-1:0]        code
);

  // configuration
  logic [TIME_BITS-1:0] margin, lead_high_time, lead_low_time, repeat_low_time;
  logic [TIME_BITS-1:0] mark_time, one_space_time, zero_space_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin          <= TIME_BITS'(MARGIN_RST);
      lead_high_time  <= TIME_BITS'(LEAD_HIGH_RST);
      lead_low_time   <= TIME_BITS'(LEAD_LOW_RST);
      repeat_low_time <= TIME_BITS'(REPEAT_LOW_RST);
      mark_time       <= TIME_BITS'(MARK_RST);
      one_space_time  <= TIME_BITS'(ONE_SPACE_RST);
      zero_space_time <= TIME_BITS'(ZERO_SPACE_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MARGIN:     margin          <= cfg_data;
        REG_LEAD_HIGH:  lead_high_time  <= cfg_data;
        REG_LEAD_LOW:   lead_low_time   <= cfg_data;
        REG_REPEAT_LOW: repeat_low_time <= cfg_data;
        REG_MARK:       mark_time       <= cfg_data;
        REG_ONE_SPACE:  one_space_time  <= cfg_data;
        REG_ZERO_SPACE: zero_space_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                 s1_valid;
  logic [TIME_BITS-1:0] s1_high, s1_low;
  logic                 s1_last;
  logic                 out_free, s1_go;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_high <= high_time;
      s1_low  <= low_time;
      s1_last <= last_symbol;
    end
  end

  // window checks
  logic lead_hi_ok, lead_lo_ok, repeat_lo_ok, mark_ok, one_ok, zero_ok;

  necir_window #(.TIME_BITS(TIME_BITS)) u_win_lead_hi (
    .value(s1_high), .target(lead_high_time), .margin(margin), .hit(lead_hi_ok));
  necir_window #(.TIME_BITS(TIME_BITS)) u_win_lead_lo (
    .value(s1_low), .target(lead_low_time), .margin(margin), .hit(lead_lo_ok));
  necir_window #(.TIME_BITS(TIME_BITS)) u_win_repeat_lo (
    .value(s1_low), .target(repeat_low_time), .margin(margin), .hit(repeat_lo_ok));
  necir_window #(.TIME_BITS(TIME_BITS)) u_win_mark (
    .value(s1_high), .target(mark_time), .margin(margin), .hit(mark_ok));
  necir_window #(.TIME_BITS(TIME_BITS)) u_win_one (
    .value(s1_low), .target(one_space_time), .margin(margin), .hit(one_ok));
  necir_window #(.TIME_BITS(TIME_BITS)) u_win_zero (
    .value(s1_low), .target(zero_space_time), .margin(margin), .hit(zero_ok));

  // frame state
  logic [1:0]             symbol_count, symbol_count_next;
  logic [BIT_COUNT_W-1:0] bit_count, bit_count_next;
  logic [CODE_BITS-1:0]   code_bits, code_bits_next;
  logic frame_failed, frame_failed_next, frame_stopped, frame_stopped_next;
  logic lead_matches, lead_matches_next, repeat_matches, repeat_matches_next;
  logic noise_lead, noise_lead_next;
  status_t                result_status;
  logic [CODE_BITS-1:0]   result_code;

  always_comb begin
    symbol_count_next   = symbol_count;
    bit_count_next      = bit_count;
    code_bits_next      = code_bits;
    frame_failed_next   = frame_failed;
    frame_stopped_next  = frame_stopped;
    lead_matches_next   = lead_matches;
    repeat_matches_next = repeat_matches;
    noise_lead_next     = noise_lead;

    if (symbol_count == 2'd0) begin
      noise_lead_next     = 32'(s1_high) < NOISE_LIMIT;
      lead_matches_next   = lead_hi_ok && lead_lo_ok;
      repeat_matches_next = lead_hi_ok && repeat_lo_ok;
      bit_count_next      = '0;
      code_bits_next      = '0;
      frame_failed_next   = 1'b0;
      frame_stopped_next  = 1'b0;
    end else if (!frame_failed && !frame_stopped && (32'(s1_high) >= GLITCH_LIMIT)) begin
      if (bit_count >= BIT_COUNT_W'(CODE_BITS)) begin
        frame_stopped_next = 1'b1;
      end else if (!mark_ok) begin
        frame_failed_next = 1'b1;
      end else if (s1_low == '0) begin
        bit_count_next     = bit_count + 1'b1;
        frame_stopped_next = 1'b1;
      end else if (one_ok) begin
        code_bits_next[bit_count[4:0]] = 1'b1;
        bit_count_next = bit_count + 1'b1;
      end else if (zero_ok) begin
        bit_count_next = bit_count + 1'b1;
      end else begin
        frame_failed_next = 1'b1;
      end
    end

    if (symbol_count != 2'd3) begin
      symbol_count_next = symbol_count + 1'b1;
    end
  end

  always_comb begin
    result_code = '0;
    if (noise_lead_next) begin
      result_status = ST_NOISE;
    end else if (symbol_count_next == 2'd2 && repeat_matches_next) begin
      result_status = ST_REPEAT;
    end else if (symbol_count_next >= 2'd2 && lead_matches_next && !frame_failed_next &&
                 bit_count_next == BIT_COUNT_W'(CODE_BITS)) begin
      result_status = ST_CODE;
      result_code   = code_bits_next;
    end else begin
      result_status = ST_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1_last)) begin
      symbol_count   <= '0;
      bit_count      <= '0;
      code_bits      <= '0;
      frame_failed   <= 1'b0;
      frame_stopped  <= 1'b0;
      lead_matches   <= 1'b0;
      repeat_matches <= 1'b0;
      noise_lead     <= 1'b0;
    end else if (s1_go) begin
      symbol_count   <= symbol_count_next;
      bit_count      <= bit_count_next;
      code_bits      <= code_bits_next;
      frame_failed   <= frame_failed_next;
      frame_stopped  <= frame_stopped_next;
      lead_matches   <= lead_matches_next;
      repeat_matches <= repeat_matches_next;
      noise_lead     <= noise_lead_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      status <= result_status;
      code   <= result_code;
    end
  end

  // checks
  a_code_only_on_decode: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_CODE) |-> (code == '0))
    else $error("code nonzero on a non-decode result");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BIT_COUNT_W'(CODE_BITS))
    else $error("bit count beyond 32");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> (symbol_count == 2'd0) && out_valid)
    else $error("frame state not cleared after result");

  a_fail_needs_lead: assert property (@(posedge clk) disable iff (rst)
    (frame_failed || frame_stopped) |-> (symbol_count >= 2'd2))
    else $error("data flags set before any data symbol");

endmodule : nec_ir_frame_decoder_core

`default_nettype wire

// ----- sim/nec_ir_frame_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_checker
// Watches the register port and both request channels of the NEC IR frame
// decoder. It keeps its own copy of the timing registers and frame state,
// predicts one report per frame-final symbol and compares every report
// field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_checker
  import necir_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [TIME_BITS_DEF-1:0] cfg_data,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic [TIME_BITS_DEF-1:0] high_time,
  input  wire logic [TIME_BITS_DEF-1:0] low_time,
  input  wire logic                     last_symbol,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic [1:0]               status,
  input  wire logic [CODE_BITS-1:0]     code,
  output int                            error_count,
  output int                            pending,
  output int                            decoded_count,
  output int                            repeat_count,
  output int                            failed_count,
  output int                            noise_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [TIME_BITS_DEF-1:0] usec_t;

  typedef struct packed {
    status_t                status;
    logic [CODE_BITS-1:0]   code;
  } frame_report_t;

  usec_t                  timing_regs [7];
  logic [1:0]             symbols_seen;
  logic [BIT_COUNT_W-1:0] bits_taken;
  logic [CODE_BITS-1:0]   code_acc;
  logic                   data_failed;
  logic                   data_stopped;
  logic                   lead_fits;
  logic                   repeat_fits;
  logic                   noisy_lead;
  frame_report_t          awaited_reports [$];

  function automatic logic fits_window(usec_t t, usec_t target);
    logic [TIME_BITS_DEF:0] lower;
    logic [TIME_BITS_DEF:0] upper;
    usec_t                  slack;
    slack = timing_regs[REG_MARGIN];
    lower = (target > slack) ? {1'b0, target} - {1'b0, slack} : '0;
    upper = {1'b0, target} + {1'b0, slack};
    return ({1'b0, t} >= lower) && ({1'b0, t} <= upper);
  endfunction

  task automatic clear_frame_state();
    symbols_seen = '0;
    bits_taken   = '0;
    code_acc     = '0;
    data_failed  = 1'b0;
    data_stopped = 1'b0;
    lead_fits    = 1'b0;
    repeat_fits  = 1'b0;
    noisy_lead   = 1'b0;
  endtask

  task automatic decode_symbol(usec_t hi_t, usec_t lo_t, logic last);
    frame_report_t report;
    logic          lead_high_fits;
    if (symbols_seen == 2'd0) begin
      lead_high_fits = fits_window(hi_t, timing_regs[REG_LEAD_HIGH]);
      noisy_lead     = hi_t < NOISE_LIMIT;
      lead_fits      = lead_high_fits && fits_window(lo_t, timing_regs[REG_LEAD_LOW]);
      repeat_fits    = lead_high_fits && fits_window(lo_t, timing_regs[REG_REPEAT_LOW]);
      bits_taken     = '0;
      code_acc       = '0;
      data_failed    = 1'b0;
      data_stopped   = 1'b0;
    end else if (!data_failed && !data_stopped && hi_t >= GLITCH_LIMIT) begin
      if (bits_taken >= CODE_BITS) begin
        data_stopped = 1'b1;
      end else if (!fits_window(hi_t, timing_regs[REG_MARK])) begin
        data_failed = 1'b1;
      end else if (lo_t == '0) begin
        bits_taken   = bits_taken + 1'b1;
        data_stopped = 1'b1;
      end else if (fits_window(lo_t, timing_regs[REG_ONE_SPACE])) begin
        code_acc[bits_taken[4:0]] = 1'b1;
        bits_taken = bits_taken + 1'b1;
      end else if (fits_window(lo_t, timing_regs[REG_ZERO_SPACE])) begin
        bits_taken = bits_taken + 1'b1;
      end else begin
        data_failed = 1'b1;
      end
    end
    if (symbols_seen != 2'd3) symbols_seen = symbols_seen + 1'b1;
    if (last) begin
      report.code = '0;
      if (noisy_lead) begin
        report.status = ST_NOISE;
      end else if (symbols_seen == 2'd2 && repeat_fits) begin
        report.status = ST_REPEAT;
      end else if (symbols_seen >= 2'd2 && lead_fits && !data_failed &&
                   bits_taken == CODE_BITS) begin
        report.status = ST_CODE;
        report.code   = code_acc;
      end else begin
        report.status = ST_FAIL;
      end
      awaited_reports.push_back(report);
      clear_frame_state();
    end
  endtask

  task automatic restore_defaults();
    timing_regs[REG_MARGIN]     = MARGIN_RST;
    timing_regs[REG_LEAD_HIGH]  = LEAD_HIGH_RST;
    timing_regs[REG_LEAD_LOW]   = LEAD_LOW_RST;
    timing_regs[REG_REPEAT_LOW] = REPEAT_LOW_RST;
    timing_regs[REG_MARK]       = MARK_RST;
    timing_regs[REG_ONE_SPACE]  = ONE_SPACE_RST;
    timing_regs[REG_ZERO_SPACE] = ZERO_SPACE_RST;
  endtask

  initial begin
    error_count   = 0;
    pending       = 0;
    decoded_count = 0;
    repeat_count  = 0;
    failed_count  = 0;
    noise_count   = 0;
    restore_defaults();
    clear_frame_state();
  end

  always @(posedge clk) begin
    frame_report_t head;
    if (rst) begin
      restore_defaults();
      clear_frame_state();
      awaited_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          error_count++;
          $error("report with none pending: status %0d, code %h", status, code);
        end else begin
          head = awaited_reports.pop_front();
          if (status !== head.status) begin
            error_count++;
            $error("status mismatch: expected %0d, got %0d", head.status, status);
          end
          if (code !== head.code) begin
            error_count++;
            $error("code mismatch: expected %h, got %h", head.code, code);
          end
          case (head.status)
            ST_CODE:   decoded_count++;
            ST_REPEAT: repeat_count++;
            ST_FAIL:   failed_count++;
            default:   noise_count++;
          endcase
        end
      end
      if (in_valid && in_ready) decode_symbol(high_time, low_time, last_symbol);
      if (cfg_write && cfg_index <= REG_ZERO_SPACE) timing_regs[cfg_index] = cfg_data;
    end
    pending = awaited_reports.size();
  end

endmodule

// ----- sim/nec_ir_frame_decoder_core_test.sv -----
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core_test
// Drives pulse symbols into the NEC IR frame decoder: a short directed set
// of edge cases, a receiver hold-off that backs the block up, then random
// data, repeat, noise and broken frames over several register settings,
// with random idle cycles on both channels. The checker does the scoring.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core_test
  import necir_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [TIME_BITS_DEF-1:0] usec_t;

  localparam int TIME_MAX     = (1 << TIME_BITS_DEF) - 1;
  localparam int SETTINGS_RUN = 5;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [TIME_BITS_DEF-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [TIME_BITS_DEF-1:0] high_time;
  logic [TIME_BITS_DEF-1:0] low_time;
  logic                     last_symbol;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic [CODE_BITS-1:0]     code;

  int error_count;
  int pending;
  int decoded_count;
  int repeat_count;
  int failed_count;
  int noise_count;

  usec_t reg_shadow [7];
  int    tx_idle_pct;
  int    rx_stall_pct;
  int    rx_hold_left;
  int    symbols_sent;
  int    frames_sent;

  nec_ir_frame_decoder_core #(.TIME_BITS(TIME_BITS_DEF)) dut (.*);

  nec_ir_frame_decoder_checker checker_i (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic int window_low(usec_t target);
    return (target > reg_shadow[REG_MARGIN]) ? int'(target) - int'(reg_shadow[REG_MARGIN]) : 0;
  endfunction

  function automatic int window_high(usec_t target);
    int sum;
    sum = int'(target) + int'(reg_shadow[REG_MARGIN]);
    return (sum > TIME_MAX) ? TIME_MAX : sum;
  endfunction

  function automatic usec_t random_time();
    return usec_t'($urandom_range(TIME_MAX, 0));
  endfunction

  function automatic usec_t pick_in(usec_t target);
    int lo_b;
    int hi_b;
    lo_b = window_low(target);
    hi_b = window_high(target);
    case ($urandom_range(9))
      0:       return usec_t'(lo_b);
      1:       return usec_t'(hi_b);
      default: return usec_t'($urandom_range(hi_b, lo_b));
    endcase
  endfunction

  function automatic usec_t pick_out(usec_t target);
    int lo_b;
    int hi_b;
    lo_b = window_low(target);
    hi_b = window_high(target);
    if (lo_b > 0 && (hi_b >= TIME_MAX || $urandom_range(1))) begin
      return $urandom_range(1) ? usec_t'(lo_b - 1) : usec_t'($urandom_range(lo_b - 1, 0));
    end else if (hi_b < TIME_MAX) begin
      return $urandom_range(1) ? usec_t'(hi_b + 1) : usec_t'($urandom_range(TIME_MAX, hi_b + 1));
    end
    return random_time();
  endfunction

  task automatic send_symbol(usec_t hi_t, usec_t lo_t, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    high_time   <= hi_t;
    low_time    <= lo_t;
    last_symbol <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    symbols_sent++;
    if (last) frames_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    cfg_write       <= 1'b1;
    cfg_index       <= idx;
    cfg_data        <= value[TIME_BITS_DEF-1:0];
    reg_shadow[idx] = usec_t'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_timing(int mg, int lh, int ll, int rl, int mk, int one_t, int zero_t);
    settle();
    write_reg(REG_MARGIN, mg);
    write_reg(REG_LEAD_HIGH, lh);
    write_reg(REG_LEAD_LOW, ll);
    write_reg(REG_REPEAT_LOW, rl);
    write_reg(REG_MARK, mk);
    write_reg(REG_ONE_SPACE, one_t);
    write_reg(REG_ZERO_SPACE, zero_t);
  endtask

  task automatic send_data_frame(int nbits, bit stop_early, int tail, int bad_at, bit bad_lead);
    usec_t hi_t;
    usec_t lo_t;
    usec_t space;
    bit    bad_side;
    bit    one_bit;
    bad_side = $urandom_range(1);
    hi_t = (bad_lead && bad_side) ? pick_out(reg_shadow[REG_LEAD_HIGH])
                                  : pick_in(reg_shadow[REG_LEAD_HIGH]);
    lo_t = (bad_lead && !bad_side) ? pick_out(reg_shadow[REG_LEAD_LOW])
                                   : pick_in(reg_shadow[REG_LEAD_LOW]);
    send_symbol(hi_t, lo_t, nbits == 0 && tail == 0);
    for (int i = 0; i < nbits; i++) begin
      if ($urandom_range(9) == 0)
        send_symbol(usec_t'($urandom_range(GLITCH_LIMIT - 1, 0)), random_time(), 1'b0);
      one_bit  = $urandom_range(1);
      bad_side = $urandom_range(1);
      space    = one_bit ? reg_shadow[REG_ONE_SPACE] : reg_shadow[REG_ZERO_SPACE];
      hi_t = (i == bad_at && bad_side) ? pick_out(reg_shadow[REG_MARK])
                                       : pick_in(reg_shadow[REG_MARK]);
      lo_t = (i == bad_at && !bad_side) ? pick_out(space) : pick_in(space);
      if (stop_early && i == nbits - 1) lo_t = '0;
      send_symbol(hi_t, lo_t, i == nbits - 1 && tail == 0);
    end
    for (int i = 0; i < tail; i++) send_symbol(random_time(), random_time(), i == tail - 1);
  endtask

  task automatic send_repeat_frame();
    bit extra;
    extra = ($urandom_range(3) == 0);
    send_symbol(pick_in(reg_shadow[REG_LEAD_HIGH]), pick_in(reg_shadow[REG_REPEAT_LOW]), 1'b0);
    send_symbol(random_time(), random_time(), !extra);
    if (extra) send_symbol(random_time(), random_time(), 1'b1);
  endtask

  task automatic send_noise_frame(int trailing);
    send_symbol(usec_t'($urandom_range(NOISE_LIMIT - 1, 0)), random_time(), trailing == 0);
    for (int i = 0; i < trailing; i++) send_symbol(random_time(), random_time(), i == trailing - 1);
  endtask

  task automatic send_random_burst();
    int n;
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++)
      send_symbol(random_time(), random_time(), i == n - 1 || $urandom_range(3) == 0);
  endtask

  task automatic run_random_frame();
    int pick;
    case ((frames_sent / 3) % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
      default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
    endcase
    pick = $urandom_range(99);
    if (pick < 40)
      send_data_frame(CODE_BITS, $urandom_range(9) < 3,
                      ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0, -1, 1'b0);
    else if (pick < 50)
      send_data_frame($urandom_range(CODE_BITS + 1, 0), $urandom_range(1), 0, -1, 1'b0);
    else if (pick < 62)
      send_data_frame(CODE_BITS, 1'b0, 0, $urandom_range(CODE_BITS - 1, 0), 1'b0);
    else if (pick < 67)
      send_data_frame(CODE_BITS, 1'b0, 0, -1, 1'b1);
    else if (pick < 80)
      send_repeat_frame();
    else if (pick < 88)
      send_noise_frame($urandom_range(3, 0));
    else
      send_random_burst();
  endtask

  initial begin
    int phase_symbols;
    int phase_frames;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    high_time    = '0;
    low_time     = '0;
    last_symbol  = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 0;
    symbols_sent = 0;
    frames_sent  = 0;
    reg_shadow[REG_MARGIN]     = MARGIN_RST;
    reg_shadow[REG_LEAD_HIGH]  = LEAD_HIGH_RST;
    reg_shadow[REG_LEAD_LOW]   = LEAD_LOW_RST;
    reg_shadow[REG_REPEAT_LOW] = REPEAT_LOW_RST;
    reg_shadow[REG_MARK]       = MARK_RST;
    reg_shadow[REG_ONE_SPACE]  = ONE_SPACE_RST;
    reg_shadow[REG_ZERO_SPACE] = ZERO_SPACE_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed edge cases, reset timing
    send_symbol(15'd0, 15'd0, 1'b1);              // noise, all zero
    send_symbol(15'd7999, 15'd32767, 1'b1);       // noise just under limit
    send_symbol(15'd32767, 15'd32767, 1'b1);      // lone symbol, not noise
    send_symbol(15'd9000, 15'd4500, 1'b1);        // lone good lead
    send_symbol(15'd9400, 15'd2650, 1'b0);        // repeat at window tops
    send_symbol(15'd0, 15'd32767, 1'b1);
    send_symbol(15'd8000, 15'd1850, 1'b0);        // lead high misses window
    send_symbol(15'd560, 15'd1690, 1'b1);
    send_symbol(15'd8600, 15'd1849, 1'b0);        // repeat space one below
    send_symbol(15'd99, 15'd0, 1'b0);             // glitch
    send_symbol(15'd560, 15'd560, 1'b1);
    send_symbol(15'd8600, 15'd4100, 1'b0);        // lead at window bottoms
    send_symbol(15'd160, 15'd1290, 1'b0);
    send_symbol(15'd960, 15'd960, 1'b0);
    send_symbol(15'd560, 15'd2090, 1'b0);
    send_symbol(15'd961, 15'd1690, 1'b0);         // mark too long
    send_symbol(15'd560, 15'd0, 1'b1);
    send_symbol(15'd9400, 15'd4900, 1'b0);
    send_symbol(15'd560, 15'd2091, 1'b0);         // space just above one window
    send_symbol(15'd560, 15'd560, 1'b1);
    send_symbol(15'd9000, 15'd4500, 1'b0);
    send_symbol(15'd560, 15'd1690, 1'b0);
    send_symbol(15'd560, 15'd0, 1'b1);            // stop after two bits

    // hold the receiver off while frames keep arriving
    rx_hold_left = 300;
    repeat (8) send_noise_frame(0);
    send_repeat_frame();

    for (int setting = 0; setting < SETTINGS_RUN; setting++) begin
      case (setting)
        1: load_timing(0, LEAD_HIGH_RST, LEAD_LOW_RST, REPEAT_LOW_RST,
                       MARK_RST, ONE_SPACE_RST, ZERO_SPACE_RST);
        2: load_timing(TIME_MAX, TIME_MAX, 0, TIME_MAX, 0, TIME_MAX, 0);
        3: load_timing($urandom_range(300, 0), $urandom_range(20000, 8500),
                       $urandom_range(6000, 3000), $urandom_range(2900, 1000),
                       $urandom_range(1000, 200), $urandom_range(2500, 1400),
                       $urandom_range(1000, 200));
        4: load_timing(1, TIME_MAX, TIME_MAX, TIME_MAX - 5, TIME_MAX, TIME_MAX - 10, 0);
        default: ;
      endcase
      phase_symbols = symbols_sent;
      phase_frames  = frames_sent;
      while (symbols_sent - phase_symbols < 70 || frames_sent - phase_frames < 3)
        run_random_frame();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Run covered %0d symbols in %0d frames over %0d timing settings and a hold-off.",
             symbols_sent, frames_sent, SETTINGS_RUN);
    $display("Reports checked: %0d codes, %0d repeats, %0d failures, %0d noise.",
             decoded_count, repeat_count, failed_count, noise_count);
    if (error_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/necir_pkg.sv
src/necir_window.sv
src/nec_ir_frame_decoder_core.sv
sim/nec_ir_frame_decoder_checker.sv
sim/nec_ir_frame_decoder_core_test.sv
